// ===== src/ppr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppr_pkg
// Shared widths, CORDIC constants and payload types for the pose reframe block.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int CoordWidth  = 32;
  localparam int AngleWidth  = 16;
  localparam int TrigStages  = 16;
  localparam int AtanCount   = 24;
  localparam int NumStages   = (TrigStages < AtanCount) ? TrigStages : AtanCount;
  // Datapath width: difference needs one extra bit, CORDIC gain growth ~1.65x
  // plus quadrant swap needs two more.
  localparam int DpWidth     = CoordWidth + 3;
  localparam int ZWidth      = 32;
  localparam logic [29:0] KinvQ30 = 30'd652032874;

  typedef logic [31:0] atan_t;

  function automatic atan_t atan_lut(input int idx);
    atan_t r;
    unique case (idx)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      default: r = 32'd81;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic signed [CoordWidth-1:0] obj_x;
    logic signed [CoordWidth-1:0] obj_y;
    logic        [AngleWidth-1:0] obj_theta;
    logic signed [CoordWidth-1:0] from_x;
    logic signed [CoordWidth-1:0] from_y;
    logic        [AngleWidth-1:0] src_theta;
    logic signed [CoordWidth-1:0] to_x;
    logic signed [CoordWidth-1:0] to_y;
    logic        [AngleWidth-1:0] dst_theta;
  } pose_req_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] out_x;
    logic signed [CoordWidth-1:0] out_y;
    logic        [AngleWidth-1:0] out_theta;
    logic                         saturated;
  } pose_rsp_t;

endpackage

// ===== src/ppr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppr_req_if / ppr_rsp_if
// Valid/ready channels for pose requests and reframed results.
// ----------------------------------------------------------------------------
interface ppr_req_if;
  logic                 valid;
  logic                 ready;
  ppr_pkg::pose_req_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppr_rsp_if;
  logic                 valid;
  logic                 ready;
  ppr_pkg::pose_rsp_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/ppr_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppr_cordic
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module ppr_cordic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [ppr_pkg::DpWidth-1:0] x_i,
  input  logic signed [ppr_pkg::DpWidth-1:0] y_i,
  input  logic signed [ppr_pkg::ZWidth-1:0]  z_i,
  output logic                               valid_o,
  output logic signed [ppr_pkg::DpWidth-1:0] x_o,
  output logic signed [ppr_pkg::DpWidth-1:0] y_o
);
  import ppr_pkg::*;

  logic signed [DpWidth-1:0] x_q [NumStages+1];
  logic signed [DpWidth-1:0] y_q [NumStages+1];
  logic signed [ZWidth-1:0]  z_q [NumStages+1];
  logic [NumStages:0]        v_q;

  assign x_q[0] = x_i;
  assign y_q[0] = y_i;
  assign z_q[0] = z_i;
  assign v_q[0] = valid_i;

  for (genvar i = 0; i < NumStages; i++) begin : g_stage
    logic signed [DpWidth-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][ZWidth-1]) begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - $signed(atan_lut(i));
        end else begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + $signed(atan_lut(i));
        end
      end
    end
  end

  assign valid_o = v_q[NumStages];
  assign x_o     = x_q[NumStages];
  assign y_o     = y_q[NumStages];

endmodule

// ===== src/planar_pose_reframe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_pose_reframe
// Re-anchors an object pose from one robot pose onto another (SE(2)).
// ----------------------------------------------------------------------------
// channel  | dir | payload                                  | handshake
// req_i    | in  | obj/from/to x,y (Q16.16), theta (bam16)  | valid/ready
// rsp_o    | out | out_x, out_y, out_theta, saturated       | valid/ready
//
// One request per cycle while the output is not stalled. A request passes
// the diff, quadrant, CORDIC, gain multiply and add/saturate registers.
// The whole pipe advances on one enable; it freezes only while the output
// register holds a result that the sink has not taken, so a stall loses
// nothing. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module planar_pose_reframe (
  input  logic     clk_i,
  input  logic     rst_ni,
  ppr_req_if.sink  req_i,
  ppr_rsp_if.source rsp_o
);
  import ppr_pkg::*;

  localparam int ProdWidth = DpWidth + 31;

  // Pipeline advances unless the output register is full and stalled.
  logic en;
  logic out_v_q;
  assign en          = !out_v_q || rsp_o.ready;
  assign req_i.ready = en;

  // ---- stage 1: differences and rotation angle ----
  logic                      s1_v_q;
  logic signed [DpWidth-1:0] s1_x_q, s1_y_q;
  logic [AngleWidth-1:0]     s1_phi_q;
  logic [AngleWidth-1:0]     s1_th_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x_q   <= DpWidth'(req_i.data.obj_x) - DpWidth'(req_i.data.from_x);
      s1_y_q   <= DpWidth'(req_i.data.obj_y) - DpWidth'(req_i.data.from_y);
      s1_phi_q <= req_i.data.dst_theta - req_i.data.src_theta;
      s1_th_q  <= req_i.data.obj_theta - req_i.data.src_theta + req_i.data.dst_theta;
    end
  end

  // ---- stage 2: exact quadrant pre-rotation ----
  logic [31:0] phi32;
  assign phi32 = {s1_phi_q, {(32-AngleWidth){1'b0}}};

  logic                      s2_v_q;
  logic signed [DpWidth-1:0] s2_x_q, s2_y_q;
  logic signed [ZWidth-1:0]  s2_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_z_q <= {2'b00, phi32[29:0]};
      unique case (phi32[31:30])
        2'd0: begin s2_x_q <= s1_x_q;  s2_y_q <= s1_y_q;  end
        2'd1: begin s2_x_q <= -s1_y_q; s2_y_q <= s1_x_q;  end
        2'd2: begin s2_x_q <= -s1_x_q; s2_y_q <= -s1_y_q; end
        default: begin s2_x_q <= s1_y_q; s2_y_q <= -s1_x_q; end
      endcase
    end
  end

  // Heading and to_x/to_y ride alongside the CORDIC in delay lines.
  localparam int DlyLen = NumStages + 3;
  logic [AngleWidth-1:0]        th_d_q [DlyLen];
  logic signed [CoordWidth-1:0] tx_d_q [DlyLen+1];
  logic signed [CoordWidth-1:0] ty_d_q [DlyLen+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      tx_d_q[0] <= req_i.data.to_x;
      ty_d_q[0] <= req_i.data.to_y;
      th_d_q[0] <= s1_th_q;
      for (int k = 1; k < DlyLen; k++) th_d_q[k] <= th_d_q[k-1];
      for (int k = 1; k <= DlyLen; k++) begin
        tx_d_q[k] <= tx_d_q[k-1];
        ty_d_q[k] <= ty_d_q[k-1];
      end
    end
  end

  // ---- CORDIC micro-rotations ----
  logic                      c_v;
  logic signed [DpWidth-1:0] c_x, c_y;

  ppr_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_v_q),
    .x_i     (s2_x_q),
    .y_i     (s2_y_q),
    .z_i     (s2_z_q),
    .valid_o (c_v),
    .x_o     (c_x),
    .y_o     (c_y)
  );

  // ---- gain stage A: magnitude times KINV ----
  logic [DpWidth-1:0] ax, ay;
  assign ax = c_x[DpWidth-1] ? DpWidth'(-c_x) : DpWidth'(c_x);
  assign ay = c_y[DpWidth-1] ? DpWidth'(-c_y) : DpWidth'(c_y);

  logic                 g1_v_q, g1_nx_q, g1_ny_q;
  logic [ProdWidth-1:0] g1_px_q, g1_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_v_q <= 1'b0;
    end else if (en) begin
      g1_v_q <= c_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g1_nx_q <= c_x[DpWidth-1];
      g1_ny_q <= c_y[DpWidth-1];
      g1_px_q <= ProdWidth'(ax) * ProdWidth'(KinvQ30);
      g1_py_q <= ProdWidth'(ay) * ProdWidth'(KinvQ30);
    end
  end

  // ---- gain stage B: round half away, restore sign ----
  logic [ProdWidth-1:0] rx_mag, ry_mag;
  assign rx_mag = (g1_px_q + (ProdWidth'(1) << 29)) >> 30;
  assign ry_mag = (g1_py_q + (ProdWidth'(1) << 29)) >> 30;

  logic                      g2_v_q;
  logic signed [DpWidth-1:0] g2_x_q, g2_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g2_v_q <= 1'b0;
    end else if (en) begin
      g2_v_q <= g1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g2_x_q <= g1_nx_q ? -DpWidth'(rx_mag) : DpWidth'(rx_mag);
      g2_y_q <= g1_ny_q ? -DpWidth'(ry_mag) : DpWidth'(ry_mag);
    end
  end

  // ---- output: add to pose and saturate ----
  localparam int SumWidth = DpWidth + 1;
  localparam logic signed [SumWidth-1:0] SumMax = SumWidth'({1'b0, {(CoordWidth-1){1'b1}}});
  localparam logic signed [SumWidth-1:0] SumMin = -SumMax - SumWidth'(1);

  logic signed [SumWidth-1:0] sx, sy;
  logic                       hx, lx, hy, ly;
  assign sx = SumWidth'(tx_d_q[DlyLen]) + SumWidth'(g2_x_q);
  assign sy = SumWidth'(ty_d_q[DlyLen]) + SumWidth'(g2_y_q);
  assign hx = sx > SumMax;
  assign lx = sx < SumMin;
  assign hy = sy > SumMax;
  assign ly = sy < SumMin;

  pose_rsp_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= g2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.out_x     <= hx ? CoordWidth'(SumMax) : lx ? CoordWidth'(SumMin)
                                                   : CoordWidth'(sx);
      out_q.out_y     <= hy ? CoordWidth'(SumMax) : ly ? CoordWidth'(SumMin)
                                                   : CoordWidth'(sy);
      out_q.out_theta <= th_d_q[DlyLen-1];
      out_q.saturated <= hx | lx | hy | ly;
    end
  end

  assign rsp_o.valid = out_v_q;
  assign rsp_o.data  = out_q;

endmodule

// ===== src/ppr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppr_checker
// Port-level checks on the pose reframe block, bound to the top level.
// ----------------------------------------------------------------------------
module ppr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input ppr_pkg::pose_rsp_t rsp_data_i
);
  import ppr_pkg::*;

  // Stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("stalled result changed");

  // Input is taken whenever the output is free.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_i |-> req_ready_i)
    else $error("ready low with empty output");

  // Ready low only while the output stalls.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> rsp_valid_i && !rsp_ready_i)
    else $error("ready low without stall");

  // Saturated flag only with an extreme coordinate.
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.saturated |->
      rsp_data_i.out_x == {1'b0, {(CoordWidth-1){1'b1}}} ||
      rsp_data_i.out_x == {1'b1, {(CoordWidth-1){1'b0}}} ||
      rsp_data_i.out_y == {1'b0, {(CoordWidth-1){1'b1}}} ||
      rsp_data_i.out_y == {1'b1, {(CoordWidth-1){1'b0}}})
    else $error("saturated without clipped coordinate");

endmodule

bind planar_pose_reframe ppr_checker u_ppr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);
